>>> src/servo_drive_enable_sequencer_core_defines.svh
// Assertion helpers for the drive enable sequencer.
`ifndef SERVO_DRIVE_ENABLE_SEQUENCER_CORE_DEFINES_SVH
`define SERVO_DRIVE_ENABLE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define SDES_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, checked only out of reset.
`define SDES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

>>> src/sdes_pkg.sv
`timescale 1ns / 1ps
package sdes_pkg;

    localparam int unsigned SW_W   = 16;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned TMO_W  = 16;
    localparam int unsigned HALF_W = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned OUT_DATA_W = 56;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 1'd1;

    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd3000;
    localparam logic [HALF_W-1:0] HALF_RST    = 8'd10;

    // statusword masks and patterns
    localparam logic [SW_W-1:0] SW_FAULT       = 16'h0008;
    localparam logic [SW_W-1:0] SW_MASK_SOD    = 16'h004F;
    localparam logic [SW_W-1:0] SW_SOD         = 16'h0040;
    localparam logic [SW_W-1:0] SW_MASK_STATE  = 16'h006F;
    localparam logic [SW_W-1:0] SW_READY       = 16'h0021;
    localparam logic [SW_W-1:0] SW_SWITCHED_ON = 16'h0023;
    localparam logic [SW_W-1:0] SW_OP_ENABLED  = 16'h0027;

    // controlwords
    localparam logic [SW_W-1:0] CW_NONE         = 16'h0000;
    localparam logic [SW_W-1:0] CW_FAULT_RESET  = 16'h0080;
    localparam logic [SW_W-1:0] CW_SHUTDOWN     = 16'h0006;
    localparam logic [SW_W-1:0] CW_SWITCH_ON    = 16'h0007;
    localparam logic [SW_W-1:0] CW_ENABLE_OP    = 16'h000F;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ENABLING = 2'd1,
        PH_ENABLED  = 2'd2,
        PH_TIMEOUT  = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [TMO_W-1:0]    attempt_count;
        logic [HALF_W-1:0]   pulse_count;
        logic                pulse_level;
        logic                request_prev;
    } t_seq_state;

    typedef struct packed {
        logic [SW_W-1:0]         control_word;
        logic signed [POS_W-1:0] command_position;
        logic                    drive_enabled;
        t_phase                  sequence_status;
    } t_seq_result;

endpackage

>>> src/sdes_step.sv
`timescale 1ns / 1ps
module sdes_step (
    input  sdes_pkg::t_seq_state               i_state,
    input  logic [sdes_pkg::TMO_W-1:0]         i_timeout_cycles,
    input  logic [sdes_pkg::HALF_W-1:0]        i_pulse_half_cycles,
    input  logic [sdes_pkg::SW_W-1:0]          i_status_word,
    input  logic signed [sdes_pkg::POS_W-1:0]  i_actual_position,
    input  logic signed [sdes_pkg::POS_W-1:0]  i_host_target,
    input  logic                               i_enable_request,
    output sdes_pkg::t_seq_state               o_state,
    output sdes_pkg::t_seq_result              o_result
);
    import sdes_pkg::*;

    t_seq_state         start;
    logic [TMO_W-1:0]   limit;
    logic [HALF_W-1:0]  half;
    logic [HALF_W-1:0]  pulse_inc;
    logic [TMO_W-1:0]   attempt_inc;
    logic [SW_W-1:0]    seq_word;
    logic               op_enabled;
    logic [SW_W-1:0]    cw;
    logic               pass_target;

    assign limit = (i_timeout_cycles == '0) ? TMO_W'(1) : i_timeout_cycles;
    assign half  = (i_pulse_half_cycles == '0) ? HALF_W'(1) : i_pulse_half_cycles;

    // a rising request restarts enabling from clean counters
    always_comb begin
        start = i_state;
        if (i_enable_request && !i_state.request_prev) begin
            start.phase         = PH_ENABLING;
            start.attempt_count = '0;
            start.pulse_count   = '0;
            start.pulse_level   = 1'b0;
        end
    end

    assign pulse_inc   = start.pulse_count + HALF_W'(1);
    assign attempt_inc = start.attempt_count + TMO_W'(1);
    assign op_enabled  = ((i_status_word & SW_FAULT) == '0)
                      && ((i_status_word & SW_MASK_STATE) == SW_OP_ENABLED);

    always_comb begin
        priority if ((i_status_word & SW_FAULT) != '0) begin
            seq_word = start.pulse_level ? CW_FAULT_RESET : CW_NONE;
        end else if ((i_status_word & SW_MASK_SOD) == SW_SOD) begin
            seq_word = CW_SHUTDOWN;
        end else if ((i_status_word & SW_MASK_STATE) == SW_READY) begin
            seq_word = CW_SWITCH_ON;
        end else if ((i_status_word & SW_MASK_STATE) == SW_SWITCHED_ON
                  || (i_status_word & SW_MASK_STATE) == SW_OP_ENABLED) begin
            seq_word = CW_ENABLE_OP;
        end else begin
            seq_word = CW_NONE;
        end
    end

    // next state
    always_comb begin
        o_state              = start;
        o_state.request_prev = i_enable_request;
        if (!i_enable_request) begin
            o_state.phase         = PH_IDLE;
            o_state.attempt_count = '0;
            o_state.pulse_count   = '0;
            o_state.pulse_level   = 1'b0;
        end else if (start.phase == PH_ENABLING) begin
            if (pulse_inc >= half) begin
                o_state.pulse_count = '0;
                o_state.pulse_level = !start.pulse_level;
            end else begin
                o_state.pulse_count = pulse_inc;
            end
            if (op_enabled) begin
                o_state.phase = PH_ENABLED;
            end else begin
                o_state.attempt_count = attempt_inc;
                if (attempt_inc >= limit) begin
                    o_state.phase = PH_TIMEOUT;
                end
            end
        end
    end

    // outputs
    always_comb begin
        cw          = CW_SHUTDOWN;
        pass_target = 1'b0;
        if (i_enable_request) begin
            unique case (start.phase)
                PH_ENABLED: begin
                    cw          = CW_ENABLE_OP;
                    pass_target = 1'b1;
                end
                PH_ENABLING: cw = seq_word;
                PH_IDLE, PH_TIMEOUT: cw = CW_SHUTDOWN;
                default: cw = CW_SHUTDOWN;
            endcase
        end
        o_result.control_word     = cw;
        o_result.command_position = pass_target ? i_host_target : i_actual_position;
        o_result.drive_enabled    = (o_state.phase == PH_ENABLED);
        o_result.sequence_status  = o_state.phase;
    end

endmodule

>>> src/servo_drive_enable_sequencer_core.sv
`timescale 1ns / 1ps
// Drive power-state enable sequencer.
// Input stream (s_axis): one item per fieldbus cycle carrying the drive
// statusword, actual position, host target and the enable-request level.
// Output stream (m_axis): one item per input item with the controlword,
// the commanded position, the enabled flag and the sequence status.
// A rising enable request starts enabling; statusword masks then pick the
// controlword until operation enabled is seen or the timeout count runs out.
// A low request drops back to idle at once.
// Latency: the result of an item is valid the cycle after it is accepted.
// Throughput: one item per clock; the whole step is one level of mask
// compares and two counter increments ahead of the result register.
// Stall: a valid result holds while m_axis_tready is low and
// s_axis_tready falls with it; an item is taken in the same cycle the held
// result leaves.
// Config: i_cfg_we writes timeout_cycles (index 0) or pulse_half_cycles
// (index 1); a zero value acts as one.
// Reset (synchronous, active low): idle, counters clear, output empty,
// timeout_cycles 3000, pulse_half_cycles 10.
module servo_drive_enable_sequencer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sdes_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sdes_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] status_word, [47:16] actual_position, [79:48] host_target,
    // [80] enable_request, [87:81] zero
    input  logic [sdes_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] control_word, [47:16] command_position, [48] drive_enabled,
    // [50:49] sequence_status, [55:51] zero
    output logic [sdes_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sdes_pkg::*;

    `include "servo_drive_enable_sequencer_core_defines.svh"

    logic [TMO_W-1:0]  r_timeout_cycles;
    logic [HALF_W-1:0] r_pulse_half_cycles;
    t_seq_state        r_state;
    t_seq_state        n_state;
    t_seq_result       r_result;
    t_seq_result       n_result;
    logic              r_out_valid;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_cycles    <= TIMEOUT_RST;
            r_pulse_half_cycles <= HALF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout_cycles <= i_cfg_data[TMO_W-1:0];
                CFG_HALF:    r_pulse_half_cycles <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sdes_step u_step (
        .i_state             (r_state),
        .i_timeout_cycles    (r_timeout_cycles),
        .i_pulse_half_cycles (r_pulse_half_cycles),
        .i_status_word       (s_axis_tdata[15:0]),
        .i_actual_position   (s_axis_tdata[47:16]),
        .i_host_target       (s_axis_tdata[79:48]),
        .i_enable_request    (s_axis_tdata[80]),
        .o_state             (n_state),
        .o_result            (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_IDLE, attempt_count: '0, pulse_count: '0,
                             pulse_level: 1'b0, request_prev: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_result.sequence_status, r_result.drive_enabled,
                            r_result.command_position, r_result.control_word};

    `SDES_ASSERT_IMPL(a_enabled_flag, m_axis_tvalid,
        m_axis_tdata[48] == (m_axis_tdata[50:49] == PH_ENABLED))
    `SDES_ASSERT_IMPL(a_hold_when_stalled, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready)
    `SDES_ASSERT_NEXT(a_low_request_idles, accept && !s_axis_tdata[80],
        r_state.phase == PH_IDLE && r_state.attempt_count == '0 && !r_state.request_prev)

endmodule
